/* hdl/port_keyed_udp_forward_rate_limiter_assert.svh */
// Assertion macros shared by the checker of the UDP forward rate limiter.
// Uses clk and arst_n from the scope that expands them.
`ifndef PORT_KEYED_UDP_FORWARD_RATE_LIMITER_ASSERT_SVH
`define PORT_KEYED_UDP_FORWARD_RATE_LIMITER_ASSERT_SVH

// Clocked property, masked while reset is asserted.
`define PKRL_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Signal must hold its value in the cycle after the condition.
`define PKRL_ASSERT_HOLD(name, cond, sig, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

/* hdl/pkrl_pkg.sv */
// Package of the port keyed UDP forward rate limiter.
// Item, result, table entry and job types plus all codes; no dependencies.
`default_nettype none
package pkrl_pkg;

	// Table geometry: one entry per UDP destination port
	localparam int PORT_ENTRIES   = 65536;
	localparam int TABLE_AW       = $clog2(PORT_ENTRIES);
	localparam int QUEUE_DEPTH_DEF = 2;

	// Protocol constants
	localparam logic [15:0] ETHTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;

	// Register reset values
	localparam logic [15:0] CONTROL_PORT_RST = 16'd0;
	localparam logic [31:0] BURST_CAP_RST    = 32'd10485760;
	localparam logic [7:0]  REFILL_RATE_RST  = 8'd1;

	// Register indexes
	localparam logic [1:0] CFG_CONTROL_PORT = 2'd0;
	localparam logic [1:0] CFG_BURST_CAP    = 2'd1;
	localparam logic [1:0] CFG_REFILL_RATE  = 2'd2;

	// Input commands
	localparam logic [1:0] CMD_PACKET = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Result actions
	localparam logic [1:0] ACT_PASS = 2'd0;
	localparam logic [1:0] ACT_DROP = 2'd1;
	localparam logic [1:0] ACT_TX   = 2'd2;
	localparam logic [1:0] ACT_DONE = 2'd3;

	// Result events
	localparam logic [1:0] EVT_NONE    = 2'd0;
	localparam logic [1:0] EVT_EXPIRED = 2'd1;
	localparam logic [1:0] EVT_RATE    = 2'd2;
	localparam logic [1:0] EVT_FWD     = 2'd3;

	// Job kinds decided by the front end
	localparam logic [2:0] KIND_PASS   = 3'd0;
	localparam logic [2:0] KIND_POLICE = 3'd1;
	localparam logic [2:0] KIND_WRITE  = 3'd2;
	localparam logic [2:0] KIND_CLEAR  = 3'd3;
	localparam logic [2:0] KIND_NOP    = 3'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic        headers_complete;
		logic [15:0] ether_type;
		logic [7:0]  ip_protocol;
		logic [15:0] udp_dport;
		logic [31:0] dst_ip;
		logic [15:0] ip_checksum;
		logic [15:0] frame_length;
		logic [63:0] now_ns;
		logic [31:0] entry_home_ip;
		logic [15:0] entry_fwd_port;
		logic [63:0] entry_expiry;
	} item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  event_code;
		logic [31:0] new_dst_ip;
		logic [15:0] new_udp_port;
		logic [15:0] new_ip_checksum;
	} result_t;

	// Tokens never exceed the burst cap, so 32 bits hold them
	typedef struct packed {
		logic        valid;
		logic [31:0] tokens;
		logic [63:0] refill_ns;
		logic [31:0] home_ip;
		logic [15:0] fwd_port;
		logic [63:0] expiry;
	} entry_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] udp_dport;
		logic [31:0] dst_ip;
		logic [15:0] ip_checksum;
		logic [15:0] frame_length;
		logic [63:0] now_ns;
		logic [31:0] home_ip;
		logic [15:0] fwd_port;
		logic [63:0] expiry;
	} job_t;

	// Policing settings handed from the register file to the back end
	typedef struct packed {
		logic [31:0] burst_cap;
		logic [7:0]  refill_rate;
	} pol_cfg_t;

endpackage
`default_nettype wire

/* hdl/pkrl_intf.sv */
// Channel interfaces of the rate limiter: input items, results, register writes.
// Depends on pkrl_pkg for the payload types.
`default_nettype none
interface pkrl_item_if import pkrl_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pkrl_result_if import pkrl_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pkrl_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/pkrl_front.sv */
// Front end: register file, item intake and classification into table jobs.
// Depends on pkrl_pkg and the channel interfaces.
`default_nettype none
module pkrl_front import pkrl_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pkrl_item_if.sink     items,
	pkrl_cfg_if.sink      cfg,
	input  wire logic     clr_busy,
	output logic          push_valid,
	input  wire logic     push_ready,
	output job_t          push_job,
	output pol_cfg_t      pol_cfg
);

	logic [15:0] ctl_port_q;
	logic [31:0] burst_cap_q;
	logic [7:0]  rate_q;
	logic        eligible;

	// Register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_port_q  <= CONTROL_PORT_RST;
			burst_cap_q <= BURST_CAP_RST;
			rate_q      <= REFILL_RATE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_CONTROL_PORT: ctl_port_q  <= cfg.data[15:0];
				CFG_BURST_CAP:    burst_cap_q <= cfg.data;
				CFG_REFILL_RATE:  rate_q      <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	assign pol_cfg.burst_cap   = burst_cap_q;
	assign pol_cfg.refill_rate = rate_q;

	// Intake stalls while the table is being cleared
	assign items.ready = push_ready && !clr_busy;
	assign push_valid  = items.valid && !clr_busy;

	// A packet goes to the table only if it is complete IPv4/UDP off the control port
	assign eligible = items.data.headers_complete
		&& (items.data.ether_type == ETHTYPE_IPV4)
		&& (items.data.ip_protocol == PROTO_UDP)
		&& (items.data.udp_dport != ctl_port_q);

	always_comb begin
		push_job.udp_dport    = items.data.udp_dport;
		push_job.dst_ip       = items.data.dst_ip;
		push_job.ip_checksum  = items.data.ip_checksum;
		push_job.frame_length = items.data.frame_length;
		push_job.now_ns       = items.data.now_ns;
		push_job.home_ip      = items.data.entry_home_ip;
		push_job.fwd_port     = items.data.entry_fwd_port;
		push_job.expiry       = items.data.entry_expiry;
		case (items.data.command)
			CMD_PACKET: push_job.kind = eligible ? KIND_POLICE : KIND_PASS;
			CMD_WRITE:  push_job.kind = KIND_WRITE;
			CMD_CLEAR:  push_job.kind = KIND_CLEAR;
			default:    push_job.kind = KIND_NOP;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/pkrl_queue.sv */
// Short job queue between the front and back ends.
// Depends on pkrl_pkg for the job type.
`default_nettype none
module pkrl_queue import pkrl_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire job_t push_job,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output job_t      pop_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/pkrl_back.sv */
// Back end: port table memory, token bucket sequencer and result register.
// Depends on pkrl_pkg and the result interface.
`default_nettype none
module pkrl_back import pkrl_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pop_valid,
	output logic          pop_ready,
	input  wire job_t     pop_job,
	input  wire pol_cfg_t pol_cfg,
	output logic          clr_busy,
	pkrl_result_if.source results
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EVAL   = 3'd2;
	localparam logic [2:0] ST_REFILL = 3'd3;
	localparam logic [2:0] ST_SPEND  = 3'd4;
	localparam logic [2:0] ST_WRITE  = 3'd5;

	entry_t              table_mem [PORT_ENTRIES];
	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [TABLE_AW-1:0] clr_idx_q;
	job_t                job_q;
	entry_t              ent_q;
	logic [63:0]         elapsed_q;
	logic                zero_q;
	logic                sat_q;
	logic [39:0]         prod_q;
	logic [31:0]         room_q;
	logic [15:0]         csum_q;
	logic [31:0]         tok_q;
	logic                res_valid_q;
	result_t             res_q;

	logic                do_pop;
	logic                out_free;
	logic                fin;
	result_t             res_d;
	logic                mem_we;
	logic [TABLE_AW-1:0] mem_wa;
	entry_t              mem_wd;
	logic                expired;
	logic [31:0]         room;
	logic                full;
	logic                big;
	logic [31:0]         tok_new;
	logic                enough;
	logic [15:0]         inv_lo;
	logic [15:0]         inv_hi;
	logic [18:0]         csum_sum;
	logic [16:0]         csum_f1;
	logic [16:0]         csum_f2;

	assign clr_busy  = (state_q == ST_CLEAR);
	assign pop_ready = (state_q == ST_IDLE);
	assign do_pop    = pop_valid && pop_ready;
	assign out_free  = !res_valid_q || results.ready;

	// Entry checks on the freshly read entry
	assign expired = job_q.now_ns > ent_q.expiry;

	// Bucket headroom and saturation tests
	assign room = pol_cfg.burst_cap - ent_q.tokens;
	assign full = ent_q.tokens >= pol_cfg.burst_cap;
	assign big  = (pol_cfg.refill_rate != '0)
		&& ((elapsed_q[63:32] != '0) || (elapsed_q[31:0] >= room));

	// Incremental checksum patch: add ~old address, add new address, fold twice
	assign inv_lo   = ~job_q.dst_ip[15:0];
	assign inv_hi   = ~job_q.dst_ip[31:16];
	assign csum_sum = 19'({1'b0, ~job_q.ip_checksum}) + 19'(17'h0ffff)
		+ 19'(inv_lo) + 19'(inv_hi)
		+ 19'(ent_q.home_ip[15:0]) + 19'(ent_q.home_ip[31:16]);
	assign csum_f1  = 17'(csum_sum[15:0]) + 17'(csum_sum[18:16]);
	assign csum_f2  = 17'(csum_f1[15:0]) + 17'(csum_f1[16]);

	// Refilled token count
	always_comb begin
		if (zero_q) begin
			tok_new = ent_q.tokens;
		end else if (sat_q || (prod_q >= {8'd0, room_q})) begin
			tok_new = pol_cfg.burst_cap;
		end else begin
			tok_new = ent_q.tokens + prod_q[31:0];
		end
	end

	assign enough = tok_q >= {16'd0, job_q.frame_length};

	// Sequencer decisions, table writes and result assembly
	always_comb begin
		state_d = state_q;
		fin     = 1'b0;
		res_d   = '0;
		mem_we  = 1'b0;
		mem_wa  = job_q.udp_dport[TABLE_AW-1:0];
		mem_wd  = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_idx_q;
				if (clr_idx_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (do_pop) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				case (job_q.kind)
					KIND_WRITE: begin
						fin              = 1'b1;
						res_d.action     = ACT_DONE;
						mem_we           = out_free;
						mem_wd.valid     = 1'b1;
						mem_wd.tokens    = pol_cfg.burst_cap;
						mem_wd.refill_ns = job_q.now_ns;
						mem_wd.home_ip   = job_q.home_ip;
						mem_wd.fwd_port  = job_q.fwd_port;
						mem_wd.expiry    = job_q.expiry;
					end
					KIND_CLEAR: begin
						fin          = 1'b1;
						res_d.action = ACT_DONE;
						mem_we       = out_free;
					end
					KIND_POLICE: begin
						if (!ent_q.valid) begin
							fin = 1'b1;
						end else if (expired) begin
							fin              = 1'b1;
							res_d.event_code = EVT_EXPIRED;
						end else begin
							state_d = ST_REFILL;
						end
					end
					KIND_PASS: begin
						fin = 1'b1;
					end
					default: begin
						fin          = 1'b1;
						res_d.action = ACT_DONE;
					end
				endcase
				if (fin && out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_REFILL: begin
				state_d = ST_SPEND;
			end
			ST_SPEND: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				fin              = 1'b1;
				mem_we           = out_free;
				mem_wd           = ent_q;
				mem_wd.refill_ns = job_q.now_ns;
				if (enough) begin
					mem_wd.tokens         = tok_q - {16'd0, job_q.frame_length};
					res_d.action          = ACT_TX;
					res_d.event_code      = EVT_FWD;
					res_d.new_dst_ip      = ent_q.home_ip;
					res_d.new_udp_port    = ent_q.fwd_port;
					res_d.new_ip_checksum = csum_q;
				end else begin
					mem_wd.tokens    = tok_q;
					res_d.action     = ACT_DROP;
					res_d.event_code = EVT_RATE;
				end
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_wa] <= mem_wd;
		end
		if (do_pop) begin
			ent_q <= table_mem[pop_job.udp_dport[TABLE_AW-1:0]];
		end
	end

	// Per-item working registers
	always_ff @(posedge clk) begin
		if (do_pop) begin
			job_q <= pop_job;
		end
		if (state_q == ST_EVAL) begin
			elapsed_q <= job_q.now_ns - ent_q.refill_ns;
		end
		if (state_q == ST_REFILL) begin
			zero_q <= (elapsed_q == '0);
			sat_q  <= full || big;
			prod_q <= 40'(elapsed_q[31:0]) * 40'(pol_cfg.refill_rate);
			room_q <= room;
			csum_q <= ~csum_f2[15:0];
		end
		if (state_q == ST_SPEND) begin
			tok_q <= tok_new;
		end
		if (fin && out_free) begin
			res_q <= res_d;
		end
	end

	// Control state: sequencer, clearing sweep, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (fin && out_free) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

endmodule
`default_nettype wire

/* hdl/port_keyed_udp_forward_rate_limiter.sv */
// UDP forwarder keyed by destination port, with a token bucket per port and
// destination rewrite. After reset the block sweeps its 65536-entry port table
// clear, one entry per cycle, and holds items.ready low until the sweep ends;
// register writes are taken throughout. Items then enter a short queue and are
// handled one at a time by a sequencer around the table memory (one write port,
// one registered read port): table commands and packets that never reach a
// bucket go through table read and evaluation, a policed packet through table
// read, expiry and elapsed time, refill and checksum, token count, and spend and
// write-back, the read-modify-write of one table entry per item. Results leave
// through an output register, so intake continues while a result waits.
// Depends on pkrl_pkg, the channel interfaces, pkrl_front, pkrl_queue, pkrl_back.
`default_nettype none
module port_keyed_udp_forward_rate_limiter import pkrl_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pkrl_item_if.sink     items,
	pkrl_result_if.source results,
	pkrl_cfg_if.sink      cfg
);

	logic     clr_busy;
	logic     push_valid;
	logic     push_ready;
	job_t     push_job;
	logic     pop_valid;
	logic     pop_ready;
	job_t     pop_job;
	pol_cfg_t pol_cfg;

	// Intake, register file and classification
	pkrl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.cfg        (cfg),
		.clr_busy   (clr_busy),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pol_cfg    (pol_cfg)
	);

	// Job queue
	pkrl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// Table and policing
	pkrl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.pol_cfg   (pol_cfg),
		.clr_busy  (clr_busy),
		.results   (results)
	);

endmodule
`default_nettype wire

/* hdl/pkrl_checker.sv */
// Port-level checker of the rate limiter, attached to the top level by bind.
// Depends on pkrl_pkg and port_keyed_udp_forward_rate_limiter_assert.svh.
`default_nettype none
`include "port_keyed_udp_forward_rate_limiter_assert.svh"
module pkrl_checker import pkrl_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    out_valid,
	input wire logic    out_ready,
	input wire result_t out_data
);

	logic stalled;
	logic is_tx;
	logic is_drop;
	logic not_tx;
	logic rw_zero;

	assign stalled = out_valid && !out_ready;
	assign is_tx   = out_valid && (out_data.action == ACT_TX);
	assign is_drop = out_valid && (out_data.action == ACT_DROP);
	assign not_tx  = out_valid && (out_data.action != ACT_TX);
	assign rw_zero = (out_data.new_dst_ip == '0) && (out_data.new_udp_port == '0)
		&& (out_data.new_ip_checksum == '0);

	// A stalled result stays offered
	`PKRL_ASSERT(a_res_valid_hold, stalled |=> out_valid, "result dropped while stalled")

	// A stalled result keeps its fields
	`PKRL_ASSERT_HOLD(a_res_data_hold, stalled, out_data, "result changed while stalled")

	// Transmit always pairs with the forwarded event, drop with rate limited
	`PKRL_ASSERT(a_tx_event, is_tx |-> (out_data.event_code == EVT_FWD), "transmit without forward")
	`PKRL_ASSERT(a_drop_event, is_drop |-> (out_data.event_code == EVT_RATE), "drop without limit")

	// Rewrite fields stay zero unless transmitting
	`PKRL_ASSERT(a_no_tx_zero, not_tx |-> rw_zero, "rewrite fields set without transmit")

endmodule

bind port_keyed_udp_forward_rate_limiter pkrl_checker u_pkrl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for the port keyed UDP forward rate limiter: a queue-fed
// sender, a stalling receiver and an in-bench policer that predicts every result.
// Depends on pkrl_pkg, the pkrl channel interfaces and the block's top module.
module tb_top;
	import pkrl_pkg::*;

	// Command code the package leaves unnamed; the block must answer it as done
	localparam logic [1:0] CMD_RESERVED = 2'd3;
	localparam int STALL_LIMIT = 300000;
	localparam int HOLD_AFTER_ITEMS = 500;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n;

	pkrl_item_if   items_ch ();
	pkrl_result_if results_ch ();
	pkrl_cfg_if    cfg_ch ();

	port_keyed_udp_forward_rate_limiter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow registers and port table of the predictor
	logic [15:0] ctrl_port_q = CONTROL_PORT_RST;
	logic [31:0] burst_q     = BURST_CAP_RST;
	logic [7:0]  rate_q      = REFILL_RATE_RST;
	entry_t      port_tbl [bit [15:0]];

	item_t   pkt_queue [$];
	result_t due_results [$];
	int      items_taken = 0;
	int      fault_count = 0;
	int      quiet_cycles = 0;

	// Stimulus cursor
	logic [63:0] clock_ns;
	logic [15:0] hot_ports [6];

	// One's complement header checksum patch for an address swap
	function automatic logic [15:0] patch_sum(input logic [15:0] check,
			input logic [31:0] old_ip, input logic [31:0] new_ip);
		logic [31:0] s;
		logic [31:0] inv;
		s = ~{16'd0, check};
		inv = ~old_ip;
		s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
		s = s + {16'd0, inv[15:0]} + {16'd0, inv[31:16]};
		s = s + {16'd0, new_ip[15:0]} + {16'd0, new_ip[31:16]};
		s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
		s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
		return ~s[15:0];
	endfunction

	// Applies one item to the shadow table and returns the result it must give
	function automatic result_t police_item(input item_t it);
		result_t r;
		entry_t e;
		logic [63:0] elapsed;
		logic [63:0] cap;
		logic [63:0] tok;
		logic [63:0] room;
		logic [63:0] add;
		r = '0;
		if (it.command != CMD_PACKET) begin
			if (it.command == CMD_WRITE) begin
				e.valid = 1'b1;
				e.tokens = burst_q;
				e.refill_ns = it.now_ns;
				e.home_ip = it.entry_home_ip;
				e.fwd_port = it.entry_fwd_port;
				e.expiry = it.entry_expiry;
				port_tbl[it.udp_dport] = e;
			end else if (it.command == CMD_CLEAR) begin
				port_tbl.delete(it.udp_dport);
			end
			r.action = ACT_DONE;
			return r;
		end
		if (!it.headers_complete || it.ether_type != ETHTYPE_IPV4 ||
				it.ip_protocol != PROTO_UDP || it.udp_dport == ctrl_port_q ||
				!port_tbl.exists(it.udp_dport)) begin
			r.action = ACT_PASS;
			return r;
		end
		e = port_tbl[it.udp_dport];
		if (it.now_ns > e.expiry) begin
			r.action = ACT_PASS;
			r.event_code = EVT_EXPIRED;
			return r;
		end
		// Refill only when time moved; a backward step is a huge gap
		elapsed = it.now_ns - e.refill_ns;
		if (elapsed != 64'd0) begin
			cap = {32'd0, burst_q};
			tok = {32'd0, e.tokens};
			if (tok >= cap) begin
				tok = cap;
			end else begin
				room = cap - tok;
				if (rate_q != 8'd0 && elapsed >= room) begin
					tok = cap;
				end else begin
					add = elapsed * {56'd0, rate_q};
					tok = (add >= room) ? cap : tok + add;
				end
			end
			e.tokens = tok[31:0];
			e.refill_ns = it.now_ns;
		end
		if (e.tokens < {16'd0, it.frame_length}) begin
			port_tbl[it.udp_dport] = e;
			r.action = ACT_DROP;
			r.event_code = EVT_RATE;
			return r;
		end
		e.tokens = e.tokens - {16'd0, it.frame_length};
		port_tbl[it.udp_dport] = e;
		r.action = ACT_TX;
		r.event_code = EVT_FWD;
		r.new_dst_ip = e.home_ip;
		r.new_udp_port = e.fwd_port;
		r.new_ip_checksum = patch_sum(it.ip_checksum, it.dst_ip, e.home_ip);
		return r;
	endfunction

	// Well-formed IPv4/UDP item with random payload fields
	function automatic item_t fresh_item(input logic [1:0] cmd, input logic [15:0] port,
			input logic [63:0] now);
		item_t it;
		it.command = cmd;
		it.headers_complete = 1'b1;
		it.ether_type = ETHTYPE_IPV4;
		it.ip_protocol = PROTO_UDP;
		it.udp_dport = port;
		it.dst_ip = $urandom;
		it.ip_checksum = 16'($urandom);
		it.frame_length = 16'($urandom_range(0, 1500));
		it.now_ns = now;
		it.entry_home_ip = $urandom;
		it.entry_fwd_port = 16'($urandom);
		it.entry_expiry = {$urandom, $urandom};
		return it;
	endfunction

	task automatic queue_random_item();
		item_t it;
		int unsigned r;
		logic [15:0] port;
		logic [1:0] cmd;
		// time mostly creeps forward, sometimes stands, steps back or jumps
		r = $urandom_range(0, 99);
		if (r < 6)
			clock_ns = clock_ns;
		else if (r < 9)
			clock_ns = clock_ns - 64'($urandom_range(1, 5000));
		else if (r < 11)
			clock_ns = clock_ns + 64'($urandom);
		else
			clock_ns = clock_ns + 64'($urandom_range(1, 40));
		r = $urandom_range(0, 99);
		if (r < 80)
			port = hot_ports[$urandom_range(0, 5)];
		else if (r < 90)
			port = ctrl_port_q;
		else
			port = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 9)
			cmd = CMD_WRITE;
		else if (r < 12)
			cmd = CMD_CLEAR;
		else if (r < 14)
			cmd = CMD_RESERVED;
		else
			cmd = CMD_PACKET;
		it = fresh_item(cmd, port, clock_ns);
		r = $urandom_range(0, 99);
		if (r < 70)
			it.entry_expiry = clock_ns + 64'($urandom_range(1000, 200000));
		else if (r < 90)
			it.entry_expiry = clock_ns + 64'($urandom_range(0, 60));
		// header noise, also on commands which must ignore it
		if ($urandom_range(0, 39) == 0)
			it.headers_complete = 1'b0;
		if ($urandom_range(0, 24) == 0)
			it.ether_type = 16'($urandom);
		if ($urandom_range(0, 24) == 0)
			it.ip_protocol = 8'($urandom);
		r = $urandom_range(0, 99);
		if (r < 10)
			it.frame_length = 16'($urandom_range(0, 100));
		else if (r < 20)
			it.frame_length = 16'($urandom);
		pkt_queue.push_back(it);
	endtask

	// Caller stands at a rising edge; valid stays high across back-to-back writes
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_CONTROL_PORT: ctrl_port_q = val[15:0];
			CFG_BURST_CAP:    burst_q = val;
			CFG_REFILL_RATE:  rate_q = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [15:0] cport, input logic [31:0] burst,
			input logic [7:0] rate);
		@(posedge clk);
		write_reg(CFG_CONTROL_PORT, {16'd0, cport});
		write_reg(CFG_BURST_CAP, burst);
		write_reg(CFG_REFILL_RATE, {24'd0, rate});
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pkt_queue.size() != 0 || due_results.size() != 0);
	endtask

	task automatic run_phase(input logic [15:0] cport, input logic [31:0] burst,
			input logic [7:0] rate, input int n);
		wait_drained();
		set_regs(cport, burst, rate);
		clock_ns = {$urandom, $urandom};
		foreach (hot_ports[i])
			hot_ports[i] = 16'($urandom);
		// keep the table edges busy now and then
		if ($urandom_range(0, 1) == 0)
			hot_ports[0] = 16'h0000;
		else
			hot_ports[0] = 16'hFFFF;
		repeat (n) queue_random_item();
	endtask

	task automatic log_fault(input string why, input result_t want, input result_t got);
		if (fault_count < 10)
			$display("%0t %s: want %0d/%0d %h %h %h, got %0d/%0d %h %h %h",
				$time, why, want.action, want.event_code, want.new_dst_ip, want.new_udp_port,
				want.new_ip_checksum, got.action, got.event_code, got.new_dst_ip,
				got.new_udp_port, got.new_ip_checksum);
		fault_count = fault_count + 1;
	endtask

	// Sender: bursts of random length separated by random gaps
	int unsigned burst_left;
	int unsigned gap_left;
	always @(posedge clk or negedge arst_n) begin : sender
		if (!arst_n) begin
			items_ch.valid <= 1'b0;
			items_ch.data <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (items_ch.valid && items_ch.ready) begin
				due_results.push_back(police_item(items_ch.data));
				void'(pkt_queue.pop_front());
				items_taken <= items_taken + 1;
			end
			if (!items_ch.valid || items_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					items_ch.valid <= 1'b0;
				end else if (pkt_queue.size() != 0) begin
					items_ch.valid <= 1'b1;
					items_ch.data <= pkt_queue[0];
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					items_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: 16-bit stall pattern renewed once it is used up, plus one long hold-off
	logic [15:0] stall_pat;
	logic [3:0]  pat_pos;
	int          hold_left;
	logic        held;
	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			stall_pat = '1;
			pat_pos = '0;
			hold_left = 0;
			held = 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			results_ch.ready <= 1'b0;
		end else if (!held && items_taken >= HOLD_AFTER_ITEMS) begin
			held = 1'b1;
			hold_left = HOLD_CYCLES;
			results_ch.ready <= 1'b0;
		end else begin
			if (pat_pos == 4'd0) begin
				case ($urandom_range(0, 3))
					0: stall_pat = '1;
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'($urandom | $urandom);
					default: stall_pat = 16'($urandom & $urandom);
				endcase
			end
			results_ch.ready <= stall_pat[pat_pos];
			pat_pos = pat_pos + 4'd1;
		end
	end

	// Result check against the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (due_results.size() == 0) begin
				log_fault("result with nothing pending", '0, results_ch.data);
			end else begin
				want = due_results.pop_front();
				if (results_ch.data.action !== want.action ||
						results_ch.data.event_code !== want.event_code ||
						results_ch.data.new_dst_ip !== want.new_dst_ip ||
						results_ch.data.new_udp_port !== want.new_udp_port ||
						results_ch.data.new_ip_checksum !== want.new_ip_checksum)
					log_fault("result mismatch", want, results_ch.data);
			end
		end
	end

	// Watchdog on cycles with no traffic on any channel
	always @(posedge clk) begin : watchdog
		if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		item_t it;
		logic [63:0] t0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_CONTROL_PORT;
		cfg_ch.data <= '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: no refill, small bucket, so spending is exact
		set_regs(16'h1234, 32'd2000, 8'd0);
		t0 = 64'h0000_0000_0000_1000;
		// no entry yet
		it = fresh_item(CMD_PACKET, 16'h0005, t0);
		pkt_queue.push_back(it);
		it = fresh_item(CMD_WRITE, 16'h0005, t0);
		it.entry_home_ip = 32'hC0A8_0001;
		it.entry_fwd_port = 16'hFFFF;
		it.entry_expiry = '1;
		pkt_queue.push_back(it);
		// spend most of the bucket, then come up short, then a free frame
		it = fresh_item(CMD_PACKET, 16'h0005, t0 + 64'd5);
		it.frame_length = 16'd1500;
		it.dst_ip = '1;
		it.ip_checksum = '0;
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'h0005, t0 + 64'd6);
		it.frame_length = 16'd1500;
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'h0005, t0 + 64'd6);
		it.frame_length = 16'd0;
		it.dst_ip = '0;
		it.ip_checksum = '1;
		pkt_queue.push_back(it);
		// header filters on a live entry
		it = fresh_item(CMD_PACKET, 16'h0005, t0 + 64'd7);
		it.headers_complete = 1'b0;
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'h0005, t0 + 64'd7);
		it.ether_type = 16'h86DD;
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'h0005, t0 + 64'd7);
		it.ip_protocol = 8'd6;
		pkt_queue.push_back(it);
		// live entry on the control port still goes to software
		it = fresh_item(CMD_WRITE, 16'h1234, t0 + 64'd8);
		it.entry_expiry = '1;
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'h1234, t0 + 64'd9);
		pkt_queue.push_back(it);
		// expiry boundary: equal time is live, one past is expired
		it = fresh_item(CMD_WRITE, 16'hFFFF, t0);
		it.entry_expiry = t0 + 64'd100;
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'hFFFF, t0 + 64'd100);
		it.frame_length = '1;
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'hFFFF, t0 + 64'd101);
		pkt_queue.push_back(it);
		// time extremes: latest possible, then back to zero
		it = fresh_item(CMD_WRITE, 16'h0000, t0);
		it.entry_expiry = '1;
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'h0000, '1);
		it.frame_length = 16'd2000;
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'h0000, '0);
		it.frame_length = 16'd1;
		pkt_queue.push_back(it);
		// clear and the reserved command
		it = fresh_item(CMD_CLEAR, 16'h0005, t0);
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'h0005, t0 + 64'd10);
		pkt_queue.push_back(it);
		it = fresh_item(CMD_RESERVED, 16'h0005, t0);
		pkt_queue.push_back(it);
		it = fresh_item(CMD_PACKET, 16'h0005, t0 + 64'd11);
		pkt_queue.push_back(it);

		// Random phases over register extremes and typical settings
		run_phase(16'hFFFF, 32'hFFFF_FFFF, 8'd255, 266);
		run_phase(16'h0000, 32'd0, 8'd255, 266);
		run_phase(16'($urandom), 32'd4000, 8'd2, 266);
		run_phase(16'($urandom), $urandom_range(500, 20000), 8'($urandom_range(0, 255)), 266);
		run_phase(16'($urandom), BURST_CAP_RST, REFILL_RATE_RST, 266);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
